// ----- rtl/zba_pkg.sv -----
package zba_pkg;

	// Default bitmap depth in 16-bit words.
	localparam int MAP_WORDS_DEF = 4096;

	// Bits held by one bitmap word.
	localparam int WORD_BITS = 16;

	// A word with every zone taken.
	localparam logic [15:0] WORD_FULL = 16'hffff;

	// Packed stream widths, rounded up to whole bytes.
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;

	// Operation codes carried in the low bits of an input item.
	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_MARK   = 2'd1;
	localparam logic [1:0] MODE_UNMARK = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_FIRST_ZONE = 1'b0;
	localparam logic CFG_LAST_ZONE  = 1'b1;

	// One result item, lowest field in the lowest bits.
	typedef struct packed {
		logic        out_of_range;
		logic        was_marked;
		logic [31:0] allocated_zone;
	} res_t;

endpackage

// ----- rtl/zba_map_mem.sv -----
module zba_map_mem import zba_pkg::*; #(
	parameter int MAP_WORDS = MAP_WORDS_DEF,
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] word_q [MAP_WORDS];
	logic [15:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			word_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= word_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/zba_ctrl.sv -----
module zba_ctrl import zba_pkg::*; #(
	parameter int MAP_WORDS = MAP_WORDS_DEF,
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
	localparam int CW = AW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	// Operation input
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_mode,
	input  logic [31:0]   in_zone,
	// Configuration
	input  logic [31:0]   first_zone,
	input  logic [31:0]   last_zone,
	// Result toward the output register
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res,
	// Bitmap memory
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SETUP = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_CHK   = 3'd4;
	localparam logic [2:0] ST_MIDX  = 3'd5;
	localparam logic [2:0] ST_MMOD  = 3'd6;
	localparam logic [2:0] ST_RESP  = 3'd7;

	localparam logic [33:0] MAP_BITS   = 34'(MAP_WORDS * WORD_BITS);
	localparam logic [28:0] MAP_WORDS_W = 29'(MAP_WORDS);
	localparam logic [CW-1:0] LAST_WORD = CW'(MAP_WORDS - 1);

	// Lowest clear bit of a word that is known not to be full.
	function automatic logic [3:0] first_clear(input logic [15:0] w);
		logic [3:0] pos;
		pos = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!w[k]) begin
				pos = 4'(k);
			end
		end
		return pos;
	endfunction

	logic [2:0]    state_q;
	logic [1:0]    mode_q;
	logic [31:0]   zone_q;
	logic [32:0]   limit_q;
	logic [CW-1:0] nwords_q;
	logic [CW-1:0] cnt_q;
	logic          pend_q;
	logic [AW-1:0] pend_idx_q;
	logic [AW-1:0] widx_q;
	logic [3:0]    bit_q;
	logic [15:0]   wword_q;
	res_t          res_q;

	logic [33:0]   idx_v;
	logic          idx_oor;
	logic [28:0]   words_raw;
	logic          limit_empty;
	logic          rd_full;
	logic [3:0]    clr_pos;
	logic          can_issue;
	logic          scan_hit;
	logic [AW+3:0] bitpos;
	logic          beyond;
	logic [31:0]   grant;
	logic [15:0]   bmask;

	// Bit index of a mark or unmark, and whether it falls off the map.
	assign idx_v   = {2'b00, zone_q} - {2'b00, first_zone} + 34'd1;
	assign idx_oor = idx_v[33] | (idx_v >= MAP_BITS);

	// Scan length before the cap at the map depth.
	assign words_raw   = 29'(({1'b0, limit_q[31:0]} + 33'd15) >> 4);
	assign limit_empty = limit_q[32] | (limit_q == '0);

	// Scan pipeline: a read is in flight while the previous word is checked.
	assign rd_full   = (mem_rdata == WORD_FULL);
	assign clr_pos   = first_clear(mem_rdata);
	assign can_issue = (cnt_q < nwords_q);
	assign scan_hit  = pend_q & ~rd_full;

	// Grant check for the clear bit found by the scan.
	assign bitpos = {widx_q, bit_q};
	assign beyond = (33'(bitpos) >= limit_q);
	assign grant  = first_zone + 32'(bitpos) - 32'd1;
	assign bmask  = 16'h0001 << bit_q;

	// Memory write port.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = widx_q;
		mem_wdata = wword_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_q[AW-1:0];
				mem_wdata = (cnt_q == '0) ? 16'h0001 : 16'h0000;
			end
			ST_CHK: begin
				mem_we = ~beyond;
			end
			ST_MMOD: begin
				mem_we    = 1'b1;
				mem_wdata = (mode_q == MODE_MARK) ? (mem_rdata | bmask)
					: (mem_rdata & ~bmask);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Memory read port.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = cnt_q[AW-1:0];
		unique case (state_q)
			ST_SCAN: begin
				mem_re = ~scan_hit & can_issue;
			end
			ST_MIDX: begin
				mem_re    = ~idx_oor;
				mem_raddr = idx_v[AW+3:4];
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			mode_q     <= '0;
			zone_q     <= '0;
			limit_q    <= '0;
			nwords_q   <= '0;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			widx_q     <= '0;
			bit_q      <= '0;
			wword_q    <= '0;
			res_q      <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_WORD) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						mode_q  <= in_mode;
						zone_q  <= in_zone;
						limit_q <= {1'b0, last_zone} - {1'b0, first_zone};
						unique case (in_mode) inside
							MODE_ALLOC: begin
								state_q <= ST_SETUP;
							end
							MODE_MARK, MODE_UNMARK: begin
								state_q <= ST_MIDX;
							end
							default: begin
								res_q   <= '0;
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SETUP: begin
					cnt_q  <= '0;
					pend_q <= 1'b0;
					if (limit_empty) begin
						res_q   <= '0;
						state_q <= ST_RESP;
					end else begin
						nwords_q <= (words_raw > MAP_WORDS_W) ? CW'(MAP_WORDS)
							: CW'(words_raw);
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_hit) begin
						widx_q  <= pend_idx_q;
						bit_q   <= clr_pos;
						wword_q <= mem_rdata | (16'h0001 << clr_pos);
						pend_q  <= 1'b0;
						state_q <= ST_CHK;
					end else if (can_issue) begin
						pend_q     <= 1'b1;
						pend_idx_q <= cnt_q[AW-1:0];
						cnt_q      <= cnt_q + CW'(1);
					end else begin
						// Every word in range is full.
						pend_q  <= 1'b0;
						res_q   <= '0;
						state_q <= ST_RESP;
					end
				end
				ST_CHK: begin
					// Fields from the top: out_of_range, was_marked, allocated_zone.
					res_q   <= {2'b00, (!beyond && (bitpos != '0)) ? grant : 32'd0};
					state_q <= ST_RESP;
				end
				ST_MIDX: begin
					if (idx_oor) begin
						res_q   <= {1'b1, 1'b0, 32'd0};
						state_q <= ST_RESP;
					end else begin
						res_q   <= '0;
						widx_q  <= idx_v[AW+3:4];
						bit_q   <= idx_v[3:0];
						state_q <= ST_MMOD;
					end
				end
				ST_MMOD: begin
					res_q.was_marked <= (mode_q == MODE_MARK) & mem_rdata[bit_q];
					state_q          <= ST_RESP;
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/zone_bitmap_allocator_unit.sv -----
// Channel   Direction  Handshake           Contents
// s_*       in         s_tvalid/s_tready   mode, zone
// m_*       out        m_tvalid/m_tready   allocated_zone, was_marked, out_of_range
// cfg_*     in         cfg_we              first_zone (index 0), last_zone (index 1)
//
// After reset the bitmap is cleared one word a cycle with s_tready low, and bit 0 of word
// 0 is set; configuration writes are taken during that time.
// Mark and unmark do one memory read and one write of the same word; an index outside
// the map touches no memory. Allocate reads the words in turn until it finds a clear bit
// and sets it if within the limit; it gives zone 0 if all are full or the limit is empty.
// A finished item waits in the output register while the next item is accepted.
module zone_bitmap_allocator_unit import zba_pkg::*; #(
	parameter int MAP_WORDS = MAP_WORDS_DEF,
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// mode [1:0], zone [33:2], zero fill [39:34]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// allocated_zone [31:0], was_marked [32], out_of_range [33], zero fill [39:34]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_wdata
);

	logic [31:0]   first_zone_q;
	logic [31:0]   last_zone_q;
	logic          m_tvalid_q;
	res_t          out_q;

	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_zone_q <= 32'd1;
			last_zone_q  <= 32'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FIRST_ZONE: first_zone_q <= cfg_wdata;
				CFG_LAST_ZONE:  last_zone_q  <= cfg_wdata;
				default:        first_zone_q <= first_zone_q;
			endcase
		end
	end

	zba_ctrl #(
		.MAP_WORDS (MAP_WORDS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_mode    (s_tdata[1:0]),
		.in_zone    (s_tdata[33:2]),
		.first_zone (first_zone_q),
		.last_zone  (last_zone_q),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	zba_map_mem #(
		.MAP_WORDS (MAP_WORDS)
	) u_map_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output register: loads when empty or when its item is being taken.
	assign res_ready = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b000000, out_q};

endmodule
